### rtl/hsd_pkg.sv
package hsd_pkg;

    // Default sizes
    localparam int unsigned HSD_MAX_CODE_LEN  = 32;
    localparam int unsigned HSD_ALPHABET_SIZE = 256;

    // Fixed field widths
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned CODE_W    = 32;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NBITS_W   = 4;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CNT7_W    = 7;
    localparam int unsigned S_TDATA_W = 64;

    // Cells per priority group
    localparam int unsigned GRP_CELLS = 8;
    localparam int unsigned GRP_IDX_W = 3;

    // Input item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    // Table write broadcast to every cell
    typedef struct packed {
        logic              we;
        logic              clr;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } load_t;

    // Pending code broadcast to every cell
    typedef struct packed {
        logic              count_ok;
        logic [LEN_W-1:0]  count;
        logic              hi_zero;
        logic [CODE_W-1:0] mask;
        logic [CODE_W-1:0] lo;
    } query_t;

    // Registered result of one priority group
    typedef struct packed {
        logic                 any;
        logic [GRP_IDX_W-1:0] idx;
    } grp_t;

endpackage

### rtl/hsd_cell.sv
module hsd_cell
    import hsd_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  load_t  ld,
    input  query_t q,
    input  logic   taken_in,
    output logic   taken_out,
    output logic   win
);

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] val_reg;
    logic              hit_reg, hit_next;
    logic              sel;

    assign sel = ld.we && (ld.sym == SYM_W'(INDEX));

    // Entry length: cleared by a table clear, zero means no code
    always_comb begin
        len_next = len_reg;
        if (ld.clr) begin
            len_next = '0;
        end else if (sel) begin
            len_next = ld.len;
        end
    end

    // Exact match of length and value against the pending code
    assign hit_next = q.count_ok && (len_reg == q.count) && q.hi_zero
                      && ((val_reg & q.mask) == q.lo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel) begin
            val_reg <= ld.code;
        end
    end

    // Priority handoff: a lower cell in the group already matched
    assign taken_out = taken_in | hit_reg;
    assign win       = hit_reg & ~taken_in;

endmodule

### rtl/hsd_group.sv
module hsd_group
    import hsd_pkg::*;
#(
    parameter int unsigned BASE  = 0,
    parameter int unsigned COUNT = GRP_CELLS
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  load_t  ld,
    input  query_t q,
    output grp_t   res
);

    logic [COUNT-1:0] taken;
    logic [COUNT-1:0] win;
    grp_t             res_reg, res_next;

    // Row of cells, lowest symbol first
    for (genvar i = 0; i < COUNT; i++) begin : g_cell
        logic taken_in;
        if (i == 0) begin : g_first
            assign taken_in = 1'b0;
        end else begin : g_next
            assign taken_in = taken[i-1];
        end
        hsd_cell #(
            .INDEX (BASE + i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ld        (ld),
            .q         (q),
            .taken_in  (taken_in),
            .taken_out (taken[i]),
            .win       (win[i])
        );
    end

    // Encode the one-hot winner
    always_comb begin
        res_next.any = taken[COUNT-1];
        res_next.idx = '0;
        for (int i = 0; i < COUNT; i++) begin
            if (win[i]) begin
                res_next.idx = res_next.idx | GRP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/huffman_stream_decoder.sv
// Load, clear and ignored items complete when accepted; the next item can be taken
// in the next cycle. Each stream bit of a data item passes through append, cell
// compare, group priority and final select, unless it overflows at append.
// Results leave through one output register; a held result stalls the bit loop.
// Reset (aresetn low, synchronous) empties the code table and the pending code.
module huffman_stream_decoder
    import hsd_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN  = HSD_MAX_CODE_LEN,
    parameter int unsigned ALPHABET_SIZE = HSD_ALPHABET_SIZE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: entry_symbol[7:0], entry_code[39:8], entry_length[45:40],
    //          data_byte[53:46], valid_bits[57:54], zero fill[63:58]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    input  logic                 s_tlast,   // stream_end
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic [SYM_W-1:0]     m_tdata,   // symbol[7:0]
    output logic [0:0]           m_tuser,   // overflow_error[0]
    output logic                 m_tlast,   // last_of_run
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int unsigned CNT_W      = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned NUM_GROUPS = (ALPHABET_SIZE + GRP_CELLS - 1) / GRP_CELLS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SHIFT = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_GRP   = 6'b001000,
        ST_SEL   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [BYTE_W-1:0]       byte_reg, byte_next;
    logic [NBITS_W-1:0]      nbits_reg, nbits_next;
    logic [NBITS_W-1:0]      bit_idx_reg, bit_idx_next;
    logic                    end_reg, end_next;
    logic [MAX_CODE_LEN-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic [SYM_W-1:0]        hold_sym_reg, hold_sym_next;
    logic                    hold_err_reg, hold_err_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]        m_sym_reg;
    logic                    m_err_reg;
    logic                    m_last_reg;

    logic                    s_accept;
    mode_t                   s_mode;
    logic [NBITS_W-1:0]      s_nbits;
    load_t                   ld;
    query_t                  q;
    logic [CNT7_W-1:0]       cnt7;
    logic [63:0]             pend64;
    logic                    cur_bit;
    logic                    overflow;
    logic                    last_bit;
    logic                    out_free;
    logic                    new_res;
    logic [SYM_W-1:0]        new_sym;
    logic                    new_err;
    logic                    blocked;
    logic                    push;
    logic                    push_last;

    grp_t                    grp_res [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]   grp_any;
    logic [NUM_GROUPS-1:0]   grp_low;
    logic                    sel_hit;
    logic [SYM_W-1:0]        sel_sym;

    // Input transfer and field unpacking
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_mode   = mode_t'(s_tuser);
    assign s_nbits  = (s_tdata[57:54] > NBITS_W'(BYTE_W)) ? NBITS_W'(BYTE_W)
                                                          : s_tdata[57:54];

    // Table write broadcast
    always_comb begin
        ld.we   = 1'b0;
        ld.clr  = 1'b0;
        ld.sym  = s_tdata[7:0];
        ld.code = s_tdata[39:8];
        ld.len  = s_tdata[45:40];
        if (s_accept) begin
            unique case (s_mode)
                MODE_LOAD:  ld.we  = 1'b1;
                MODE_CLEAR: ld.clr = 1'b1;
                default:    ;
            endcase
        end
    end

    // Pending code broadcast
    assign cnt7   = CNT7_W'(cnt_reg);
    assign pend64 = 64'(pend_reg);
    assign q.count_ok = !cnt7[CNT7_W-1] && (cnt7 != '0);
    assign q.count    = cnt7[LEN_W-1:0];
    assign q.hi_zero  = (pend64[63:32] == 32'd0);
    assign q.mask     = (cnt7 >= CNT7_W'(CODE_W)) ? '1 : ((32'd1 << cnt7[4:0]) - 32'd1);
    assign q.lo       = pend64[31:0];

    // Cell groups
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        localparam int unsigned LEFT  = ALPHABET_SIZE - g * GRP_CELLS;
        localparam int unsigned COUNT = (LEFT >= GRP_CELLS) ? GRP_CELLS : LEFT;
        hsd_group #(
            .BASE  (g * GRP_CELLS),
            .COUNT (COUNT)
        ) u_group (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ld      (ld),
            .q       (q),
            .res     (grp_res[g])
        );
        assign grp_any[g] = grp_res[g].any;
    end

    // Lowest matching group wins
    assign grp_low = grp_any & (~grp_any + NUM_GROUPS'(1));
    assign sel_hit = |grp_any;
    always_comb begin
        sel_sym = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (grp_low[g]) begin
                sel_sym = sel_sym | (SYM_W'(g) << GRP_IDX_W) | SYM_W'(grp_res[g].idx);
            end
        end
    end

    // Bit loop helpers
    assign cur_bit  = byte_reg[3'(3'd7 - bit_idx_reg[2:0])];
    assign overflow = (cnt_reg == CNT_W'(MAX_CODE_LEN));
    assign last_bit = ((bit_idx_reg + NBITS_W'(1)) == nbits_reg);
    assign out_free = !m_valid_reg || m_tready;

    // A new result displaces the held one; wait if the output is busy
    assign new_res = ((state_reg == ST_SHIFT) && overflow)
                     || ((state_reg == ST_SEL) && sel_hit);
    assign new_sym = (state_reg == ST_SEL) ? sel_sym : '0;
    assign new_err = (state_reg == ST_SHIFT);
    assign blocked = new_res && hold_vld_reg && !out_free;

    assign push_last = (state_reg == ST_DONE);
    assign push = (new_res && hold_vld_reg && !blocked)
                  || (push_last && hold_vld_reg && out_free);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        nbits_next    = nbits_reg;
        bit_idx_next  = bit_idx_reg;
        end_next      = end_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        hold_vld_next = hold_vld_reg;
        hold_sym_next = hold_sym_reg;
        hold_err_next = hold_err_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_mode)
                        MODE_DATA: begin
                            byte_next    = s_tdata[53:46];
                            nbits_next   = s_nbits;
                            end_next     = s_tlast;
                            bit_idx_next = '0;
                            state_next   = (s_nbits == '0) ? ST_DONE : ST_SHIFT;
                        end
                        MODE_CLEAR: begin
                            pend_next = '0;
                            cnt_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SHIFT: begin
                if (!blocked) begin
                    if (overflow) begin
                        pend_next    = '0;
                        cnt_next     = '0;
                        bit_idx_next = bit_idx_reg + NBITS_W'(1);
                        state_next   = last_bit ? ST_DONE : ST_SHIFT;
                    end else begin
                        pend_next  = {pend_reg[MAX_CODE_LEN-2:0], cur_bit};
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: state_next = ST_GRP;
            ST_GRP: state_next = ST_SEL;
            ST_SEL: begin
                if (!blocked) begin
                    if (sel_hit) begin
                        pend_next = '0;
                        cnt_next  = '0;
                    end
                    bit_idx_next = bit_idx_reg + NBITS_W'(1);
                    state_next   = last_bit ? ST_DONE : ST_SHIFT;
                end
            end
            ST_DONE: begin
                if (!hold_vld_reg || out_free) begin
                    hold_vld_next = 1'b0;
                    if (end_reg) begin
                        pend_next = '0;
                        cnt_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Keep the newest result back until the next one or the item end
        if (new_res && !blocked) begin
            hold_vld_next = 1'b1;
            hold_sym_next = new_sym;
            hold_err_next = new_err;
        end
    end

    // Output register
    assign m_valid_next = push ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            hold_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            hold_vld_reg <= hold_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        nbits_reg    <= nbits_next;
        bit_idx_reg  <= bit_idx_next;
        end_reg      <= end_next;
        hold_sym_reg <= hold_sym_next;
        hold_err_reg <= hold_err_next;
        if (push) begin
            m_sym_reg  <= hold_sym_reg;
            m_err_reg  <= hold_err_reg;
            m_last_reg <= push_last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_sym_reg;
    assign m_tuser[0] = m_err_reg;
    assign m_tlast    = m_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_CODE_LEN))
        else $error("pending count beyond maximum code length");

    a_idle_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_vld_reg)
        else $error("held result not flushed at item end");

    a_shift_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) && !blocked && !overflow
        |=> cnt_reg == CNT_W'($past(cnt_reg) + CNT_W'(1)))
        else $error("append did not advance pending count");

    a_sel_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL) |-> cnt_reg != '0)
        else $error("select with empty pending code");
`endif

endmodule

### verif/tb_huffman_stream_decoder.sv
module tb_huffman_stream_decoder;
    import hsd_pkg::*;

    // Mode 3 is not decoded by the block; it must be dropped without results
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_RESULTS = 8;
    localparam int RAND_ITEMS  = 150;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;

    // One input transfer, unpacked from s_tdata/s_tuser/s_tlast
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SYM_W-1:0]   sym;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  dbyte;
        logic [NBITS_W-1:0] nbits;
        logic               fin;
    } stim_t;

    // One decoded result
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             ovf;
        logic             last;
    } res_t;

    // Stimulus table row; typed rows carry their expected result (zero or one)
    typedef struct packed {
        stim_t      stim;
        logic       typed;
        logic [3:0] n_typed;
        res_t       res;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SYM_W-1:0]     m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;

    // Decoder model state
    logic [LEN_W-1:0]  tbl_len  [HSD_ALPHABET_SIZE];
    logic [CODE_W-1:0] tbl_code [HSD_ALPHABET_SIZE];
    logic [63:0]       pend_bits;
    int                pend_cnt;
    res_t              decoded [MAX_RESULTS];
    res_t              expected_q [$];

    // Run control and bookkeeping
    bit idle_en     = 1'b1;
    int hold_cycles = 0;
    int quiet_from  = 32'h7fff_ffff;
    int n_errors    = 0;
    int n_checked   = 0;
    int n_overflows = 0;
    int n_items     = 0;
    int n_data      = 0;
    int n_loads     = 0;
    int n_clears    = 0;
    int n_ignored   = 0;

    huffman_stream_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock: period 2
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("huffman_stream_decoder test failed");
        $finish;
    end

    // Stimulus builders; fields unused by the mode get random values
    function automatic stim_t load_entry(input logic [SYM_W-1:0] sym,
                                         input logic [CODE_W-1:0] code,
                                         input logic [LEN_W-1:0] len);
        stim_t it;
        it       = '0;
        it.mode  = MODE_LOAD;
        it.sym   = sym;
        it.code  = code;
        it.len   = len;
        it.dbyte = 8'($urandom);
        it.nbits = 4'($urandom);
        it.fin   = 1'($urandom);
        return it;
    endfunction

    function automatic stim_t data_byte_item(input logic [BYTE_W-1:0] dbyte,
                                             input logic [NBITS_W-1:0] nbits,
                                             input logic fin);
        stim_t it;
        it       = '0;
        it.mode  = MODE_DATA;
        it.sym   = 8'($urandom);
        it.code  = $urandom;
        it.len   = 6'($urandom);
        it.dbyte = dbyte;
        it.nbits = nbits;
        it.fin   = fin;
        return it;
    endfunction

    function automatic stim_t clear_item();
        stim_t it;
        it      = data_byte_item(8'($urandom), 4'($urandom), 1'($urandom));
        it.mode = MODE_CLEAR;
        return it;
    endfunction

    function automatic stim_t unused_item();
        stim_t it;
        it      = data_byte_item(8'($urandom), 4'($urandom), 1'($urandom));
        it.mode = MODE_UNUSED;
        return it;
    endfunction

    function automatic row_t row_of(input stim_t it);
        row_t r;
        r      = '0;
        r.stim = it;
        return r;
    endfunction

    function automatic row_t typed_row(input stim_t it, input int n, input res_t res);
        row_t r;
        r         = row_of(it);
        r.typed   = 1'b1;
        r.n_typed = 4'(n);
        r.res     = res;
        return r;
    endfunction

    // Table search: exact length and value match, lowest symbol wins
    function automatic int lookup_symbol();
        logic [63:0] mask;
        for (int s = 0; s < HSD_ALPHABET_SIZE; s++) begin
            if (tbl_len[s] != 0 && int'(tbl_len[s]) == pend_cnt) begin
                mask = (64'd1 << tbl_len[s]) - 64'd1;
                if (({32'd0, tbl_code[s]} & mask) == pend_bits) begin
                    return s;
                end
            end
        end
        return -1;
    endfunction

    // Apply one item to the decoder model; results land in decoded[], count returned
    function automatic int decode_item(input stim_t it);
        int n;
        int nb;
        int hit;
        n = 0;
        case (it.mode)
            MODE_LOAD: begin
                tbl_len[it.sym]  = it.len;
                tbl_code[it.sym] = it.code;
            end
            MODE_CLEAR: begin
                for (int s = 0; s < HSD_ALPHABET_SIZE; s++) tbl_len[s] = '0;
                pend_bits = '0;
                pend_cnt  = 0;
            end
            MODE_DATA: begin
                nb = (it.nbits > BYTE_W) ? BYTE_W : it.nbits;
                for (int i = 0; i < nb; i++) begin
                    if (pend_cnt >= HSD_MAX_CODE_LEN) begin
                        // overflow: pending code and this bit are dropped
                        decoded[n] = {8'h00, 1'b1, 1'b0};
                        n++;
                        pend_bits = '0;
                        pend_cnt  = 0;
                    end else begin
                        pend_bits = {pend_bits[62:0], it.dbyte[BYTE_W-1-i]};
                        pend_cnt++;
                        hit = lookup_symbol();
                        if (hit >= 0) begin
                            decoded[n] = {hit[7:0], 1'b0, 1'b0};
                            n++;
                            pend_bits = '0;
                            pend_cnt  = 0;
                        end
                    end
                end
                if (it.fin) begin
                    pend_bits = '0;
                    pend_cnt  = 0;
                end
                if (n > 0) decoded[n-1].last = 1'b1;
            end
            default: ;
        endcase
        return n;
    endfunction

    // Offer one item, wait for the transfer, then queue its expected results
    task automatic send_item(input row_t r);
        int n;
        if (n_items >= quiet_from) idle_en = 1'b0;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.stim.mode;
        s_tlast  <= r.stim.fin;
        s_tdata  <= {6'd0, r.stim.nbits, r.stim.dbyte, r.stim.len, r.stim.code, r.stim.sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = decode_item(r.stim);
        if (r.typed) begin
            if (r.n_typed != 0) expected_q.push_back(r.res);
        end else begin
            for (int i = 0; i < n; i++) expected_q.push_back(decoded[i]);
        end
        case (r.stim.mode)
            MODE_LOAD:  n_loads++;
            MODE_DATA:  n_data++;
            MODE_CLEAR: n_clears++;
            default:    n_ignored++;
        endcase
        if (r.stim.mode != MODE_UNUSED) n_items++;
    endtask

    // Stop offering and let every outstanding result drain
    task automatic wait_for_results(input int extra);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Result side ready pacing: random stall bursts, one long hold-off on request
    always begin : sink_pacing
        @(posedge aclk);
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            repeat (hold_cycles) @(posedge aclk);
            hold_cycles = 0;
            m_tready <= 1'b1;
        end else if (idle_en && aresetn && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: every transfer against the oldest expectation
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_checked++;
            if (m_tuser[0]) n_overflows++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: symbol %0h overflow_error %0b last_of_run %0b",
                       m_tdata, m_tuser[0], m_tlast);
                n_errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_tdata !== want.symbol) begin
                    $error("symbol: expected %0h, got %0h", want.symbol, m_tdata);
                    n_errors++;
                end
                if (m_tuser[0] !== want.ovf) begin
                    $error("overflow_error: expected %0b, got %0b", want.ovf, m_tuser[0]);
                    n_errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        row_t        rows [$];
        logic        bitq [$];
        logic [31:0] leaf_code [16];
        int          leaf_len  [16];
        logic [7:0]  leaf_sym  [16];
        bit          sym_used  [256];
        logic [7:0]  byte_v;
        stim_t       it;
        int          phase;
        int          kind;
        int          k;
        int          maxl;
        int          n_leaf;
        int          idx;
        int          nb;
        int          nfield;
        int          s;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_LOAD;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        for (int i = 0; i < HSD_ALPHABET_SIZE; i++) begin
            tbl_len[i]  = '0;
            tbl_code[i] = '0;
        end
        pend_bits = '0;
        pend_cnt  = 0;

        // Directed table
        // empty table: 32 bits pend without a match, the 33rd overflows
        rows.push_back(typed_row(data_byte_item(8'hFF, 4'd8, 1'b0), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'hFF, 4'd8, 1'b0), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'hFF, 4'd8, 1'b0), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'hFF, 4'd8, 1'b0), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'h80, 4'd1, 1'b0), 1, {8'h00, 1'b1, 1'b1}));
        // small prefix code: 0 -> 41, 10 -> 42, 11 -> 00 (bits above length ignored)
        rows.push_back(typed_row(load_entry(8'h41, 32'h0000_0000, 6'd1), 0, '0));
        rows.push_back(typed_row(load_entry(8'h42, 32'h0000_0002, 6'd2), 0, '0));
        rows.push_back(typed_row(load_entry(8'h00, 32'hFFFF_FFFF, 6'd2), 0, '0));
        // full byte of single-bit codes: eight results
        rows.push_back(row_of(data_byte_item(8'h00, 4'd8, 1'b0)));
        rows.push_back(row_of(data_byte_item(8'hB2, 4'd6, 1'b0)));
        // zero bit count, saturated bit count, unused mode
        rows.push_back(typed_row(data_byte_item(8'h5A, 4'd0, 1'b0), 0, '0));
        rows.push_back(row_of(data_byte_item(8'h00, 4'd15, 1'b0)));
        rows.push_back(typed_row(unused_item(), 0, '0));
        // duplicate code: lower symbol wins, then the entry is removed
        rows.push_back(typed_row(load_entry(8'h05, 32'h0000_0000, 6'd1), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'h7F, 4'd1, 1'b0), 1, {8'h05, 1'b0, 1'b1}));
        rows.push_back(typed_row(load_entry(8'h05, 32'h0000_0000, 6'd0), 0, '0));
        // over-long code is stored but can never match
        rows.push_back(typed_row(load_entry(8'h80, 32'h1234_5678, 6'd63), 0, '0));
        // end of stream drops the pending bit
        rows.push_back(typed_row(data_byte_item(8'h80, 4'd1, 1'b1), 0, '0));
        rows.push_back(typed_row(data_byte_item(8'h00, 4'd1, 1'b0), 1, {8'h41, 1'b0, 1'b1}));
        // clear, then a full-length 32 bit code
        rows.push_back(typed_row(clear_item(), 0, '0));
        rows.push_back(typed_row(load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32), 0, '0));
        rows.push_back(row_of(data_byte_item(8'hFF, 4'd8, 1'b0)));
        rows.push_back(row_of(data_byte_item(8'hFF, 4'd8, 1'b0)));
        rows.push_back(row_of(data_byte_item(8'hFF, 4'd8, 1'b0)));
        rows.push_back(row_of(data_byte_item(8'hFF, 4'd8, 1'b0)));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_item(rows[i]);

        // Random part: mostly complete prefix codes with encoded streams
        quiet_from = n_items + RAND_ITEMS - 30;
        phase      = 0;
        while (n_items < quiet_from + 30) begin
            // long receiver hold-off while the sender keeps offering
            if (phase == 1) hold_cycles = HOLD_CYCLES;
            // sender pause until everything has drained
            if (phase == 3) wait_for_results(TAIL_CYCLES);
            kind = $urandom_range(0, 9);

            if (kind < 6 || phase < 2) begin
                // build a complete prefix code by splitting leaves
                send_item(row_of(clear_item()));
                k    = $urandom_range(2, 12);
                maxl = $urandom_range(4, 11);
                leaf_code[0] = '0;
                leaf_len[0]  = 0;
                n_leaf       = 1;
                while (n_leaf < k) begin
                    idx = $urandom_range(0, n_leaf - 1);
                    if (leaf_len[idx] >= maxl) begin
                        for (int j = 0; j < n_leaf; j++) begin
                            if (leaf_len[j] < maxl) idx = j;
                        end
                    end
                    leaf_code[n_leaf] = {leaf_code[idx][30:0], 1'b1};
                    leaf_len[n_leaf]  = leaf_len[idx] + 1;
                    leaf_code[idx]    = {leaf_code[idx][30:0], 1'b0};
                    leaf_len[idx]++;
                    n_leaf++;
                end
                // distinct symbols, junk above the code length
                for (int j = 0; j < 256; j++) sym_used[j] = 1'b0;
                for (int j = 0; j < n_leaf; j++) begin
                    do s = $urandom_range(0, 255); while (sym_used[s]);
                    sym_used[s] = 1'b1;
                    leaf_sym[j] = 8'(s);
                    send_item(row_of(load_entry(leaf_sym[j],
                                                leaf_code[j] | ($urandom << leaf_len[j]),
                                                6'(leaf_len[j]))));
                end
                // encode a random symbol string, MSB first
                bitq.delete();
                while (bitq.size() < 48 && (bitq.size() == 0 || $urandom_range(0, 7) != 0))
                begin
                    idx = $urandom_range(0, n_leaf - 1);
                    for (int b = leaf_len[idx] - 1; b >= 0; b--) begin
                        bitq.push_back(leaf_code[idx][b]);
                    end
                end
                // cut into bytes of random bit counts
                while (bitq.size() != 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(row_of(data_byte_item(8'($urandom), 4'd0, 1'b0)));
                    end
                    nb = $urandom_range(1, 8);
                    if (nb > bitq.size()) nb = bitq.size();
                    nfield = nb;
                    if (nb == 8 && $urandom_range(0, 2) == 0) nfield = $urandom_range(9, 15);
                    byte_v = 8'($urandom);
                    for (int b = 0; b < nb; b++) byte_v[7-b] = bitq.pop_front();
                    send_item(row_of(data_byte_item(byte_v, 4'(nfield),
                                     bitq.size() == 0 && $urandom_range(0, 3) != 0)));
                end
            end else if (kind < 9) begin
                // noise: arbitrary loads, bytes, clears and unused items
                repeat ($urandom_range(6, 14)) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: it = load_entry(8'($urandom), $urandom,
                                                    6'(($urandom_range(0, 3) == 0) ?
                                                       $urandom_range(0, 63) :
                                                       $urandom_range(0, 8)));
                        4, 5, 6, 7: it = data_byte_item(8'($urandom),
                                                        4'($urandom_range(0, 15)),
                                                        $urandom_range(0, 4) == 0);
                        8:          it = unused_item();
                        default:    it = clear_item();
                    endcase
                    send_item(row_of(it));
                end
            end else begin
                // sparse table of long codes: drives overflows
                send_item(row_of(clear_item()));
                repeat ($urandom_range(1, 2)) begin
                    send_item(row_of(load_entry(8'($urandom), $urandom,
                                                6'($urandom_range(16, 32)))));
                end
                repeat (6) send_item(row_of(data_byte_item(8'($urandom), 4'd8, 1'b0)));
                send_item(row_of(data_byte_item(8'($urandom), 4'($urandom_range(1, 8)),
                                                1'b1)));
            end
            phase++;
        end

        wait_for_results(TAIL_CYCLES);

        $display("Run covered %0d transfers: %0d data bytes, %0d loads, %0d clears, %0d ignored.",
                 n_items + n_ignored, n_data, n_loads, n_clears, n_ignored);
        $display("Checked %0d decoded results, %0d of them overflow errors, over %0d code phases.",
                 n_checked, n_overflows, phase);
        if (n_errors == 0) begin
            $display("huffman_stream_decoder test passed");
        end else begin
            $display("huffman_stream_decoder test failed");
        end
        $finish;
    end

endmodule

### huffman_stream_decoder.f
rtl/hsd_pkg.sv
rtl/hsd_cell.sv
rtl/hsd_group.sv
rtl/huffman_stream_decoder.sv
verif/tb_huffman_stream_decoder.sv
